// ===== hw/rtl/keyed_io_stats_table_defines.svh =====
`ifndef KEYED_IO_STATS_TABLE_DEFINES_SVH
`define KEYED_IO_STATS_TABLE_DEFINES_SVH

// same-cycle implication
`define KIST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define KIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/kist_pkg.sv =====
package kist_pkg;

   localparam logic [1:0] STATUS_FILTERED = 2'd0;
   localparam logic [1:0] STATUS_UPDATED  = 2'd1;
   localparam logic [1:0] STATUS_INSERTED = 2'd2;
   localparam logic [1:0] STATUS_DROPPED  = 2'd3;

   typedef struct packed {
      logic        is_write;
      logic [31:0] process_id;
      logic [31:0] descriptor;
      logic [31:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] event_total;
      logic [63:0] byte_total;
   } rsp_type;

   typedef struct packed {
      logic        is_write;
      logic [31:0] pid;
      logic [31:0] fd;
      logic [31:0] events;
      logic [63:0] bytes;
   } entry_type;

   typedef struct packed {
      logic load;
      logic step;
      logic take_hit;
      logic take_new;
      logic take_drop;
      logic write;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic filtered;
      logic more;
      logic hit;
      logic full;
      logic out_free;
   } sts_type;

endpackage

// ===== hw/rtl/kist_ram.sv =====
module kist_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16,
     parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/kist_ctrl.sv =====
module kist_ctrl
   import kist_pkg::*;
   (input  logic    clock,
    input  logic    reset,
    input  logic    req_valid,
    output logic    req_stall,
    input  sts_type sts,
    output cmd_type cmd);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_WRITE  = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.filtered ? ST_DONE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_WRITE;
            end else if (!sts.more) begin
               if (sts.full) begin
                  cmd.take_drop = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  cmd.take_new = 1'b1;
                  state_in     = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/kist_dpath.sv =====
module kist_dpath
   import kist_pkg::*;
   #(parameter int TABLE_ENTRIES = 1024)
   (input  logic        clock,
    input  logic        reset,
    input  req_type     req_payload,
    input  logic        csr_write,
    input  logic [31:0] csr_data,
    input  cmd_type     cmd,
    output sts_type     sts,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_type     rsp_payload);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = $bits(entry_type);

   logic [31:0]   target_ff;
   logic [CW-1:0] used_ff;
   logic [CW-1:0] rd_idx_ff;
   logic          cmp_vld_ff;
   logic [IW-1:0] cmp_idx_ff;
   req_type       key_ff;
   logic [1:0]    res_status_ff;
   logic [31:0]   res_events_ff;
   logic [63:0]   res_bytes_ff;
   logic [IW-1:0] wr_addr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [EW-1:0] rd_bits;
   entry_type     rd_entry;
   entry_type     wr_entry;
   logic          rd_en;
   logic          match;

   assign rd_entry = entry_type'(rd_bits);
   assign rd_en    = cmd.step && sts.more;
   assign match    = (rd_entry.is_write == key_ff.is_write)
                  && (rd_entry.pid == key_ff.process_id)
                  && (rd_entry.fd == key_ff.descriptor);

   assign wr_entry.is_write = key_ff.is_write;
   assign wr_entry.pid      = key_ff.process_id;
   assign wr_entry.fd       = key_ff.descriptor;
   assign wr_entry.events   = res_events_ff;
   assign wr_entry.bytes    = res_bytes_ff;

   assign sts.filtered = (target_ff != 32'd0) && (req_payload.process_id != target_ff);
   assign sts.more     = (rd_idx_ff < used_ff);
   assign sts.hit      = cmp_vld_ff && match;
   assign sts.full     = (used_ff == CW'(TABLE_ENTRIES));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   kist_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES), .AW(IW)) u_ram (
      .clock (clock),
      .we    (cmd.write),
      .waddr (wr_addr_ff),
      .wdata (EW'(wr_entry)),
      .re    (rd_en),
      .raddr (rd_idx_ff[IW-1:0]),
      .rdata (rd_bits));

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         used_ff      <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            target_ff <= csr_data;
         end
         if (cmd.load) begin
            rd_idx_ff  <= '0;
            cmp_vld_ff <= 1'b0;
         end else if (cmd.step) begin
            cmp_vld_ff <= rd_en;
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + CW'(1);
            end
         end
         if (cmd.write && (res_status_ff == STATUS_INSERTED)) begin
            used_ff <= used_ff + CW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff        <= req_payload;
         res_status_ff <= STATUS_FILTERED;
         res_events_ff <= '0;
         res_bytes_ff  <= '0;
      end
      if (cmd.step) begin
         cmp_idx_ff <= rd_idx_ff[IW-1:0];
      end
      if (cmd.take_hit) begin
         res_status_ff <= STATUS_UPDATED;
         res_events_ff <= rd_entry.events + 32'd1;
         res_bytes_ff  <= rd_entry.bytes + {32'd0, key_ff.byte_count};
         wr_addr_ff    <= cmp_idx_ff;
      end
      if (cmd.take_new) begin
         res_status_ff <= STATUS_INSERTED;
         res_events_ff <= 32'd1;
         res_bytes_ff  <= {32'd0, key_ff.byte_count};
         wr_addr_ff    <= used_ff[IW-1:0];
      end
      if (cmd.take_drop) begin
         res_status_ff <= STATUS_DROPPED;
         res_events_ff <= '0;
         res_bytes_ff  <= '0;
      end
      if (cmd.emit) begin
         rsp_ff.status      <= res_status_ff;
         rsp_ff.event_total <= res_events_ff;
         rsp_ff.byte_total  <= res_bytes_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/keyed_io_stats_table.sv =====
// Per-key I/O statistics table.
// req channel: one I/O event per request (direction, pid, descriptor, bytes),
//   taken when req_valid is high and req_stall is low.
// rsp channel: one result per request (status, event total, byte total),
//   held on rsp_payload while rsp_stall is high.
// csr channel: write of the target pid; csr_ready is always high.
// A request walks the occupied slots one per cycle through the table RAM
// read port until a match, then writes back one entry; a drop writes
// nothing and a filtered request skips the walk. The result is loaded
// once the output is free, and req_stall stays high until then, so no
// new request is taken before the result of the last one is loaded.
// The finished result moves into an output register, so the next request
// is taken while a stalled result still waits.
// Reset clears the target pid, the fill count and the valid output; the
// table RAM is not cleared, as slots fill in order and only slots below
// the fill count are read.
`include "keyed_io_stats_table_defines.svh"

module keyed_io_stats_table
   import kist_pkg::*;
   #(parameter int TABLE_ENTRIES = 1024)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_type     req_payload,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_type     rsp_payload,
    input  logic        csr_valid,
    output logic        csr_ready,
    input  logic [31:0] csr_data);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   kist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd));

   kist_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload));

   `KIST_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   `KIST_ASSERT_NOW(a_filtered_zero, clock, reset, rsp_valid && (rsp_payload.status == STATUS_FILTERED), (rsp_payload.event_total == 32'd0) && (rsp_payload.byte_total == 64'd0))
   `KIST_ASSERT_NOW(a_dropped_zero, clock, reset, rsp_valid && (rsp_payload.status == STATUS_DROPPED), (rsp_payload.event_total == 32'd0) && (rsp_payload.byte_total == 64'd0))
   `KIST_ASSERT_NOW(a_insert_one, clock, reset, rsp_valid && (rsp_payload.status == STATUS_INSERTED), rsp_payload.event_total == 32'd1)

endmodule
